// File: hdl/oldest_or_richest_service_queue_defines.svh
// Assertion macros shared by the service queue RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef OLDEST_OR_RICHEST_SERVICE_QUEUE_DEFINES_SVH
`define OLDEST_OR_RICHEST_SERVICE_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define ORSQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ORSQ_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define ORSQ_ASSERT(label, prop, msg)
`define ORSQ_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// File: hdl/orsq_pkg.sv
// Shared types and constants for the oldest-or-richest service queue.
// Depends on nothing.
`timescale 1ns / 1ps
package orsq_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int AMOUNT_BITS_DEF = 32;
	localparam int NUMBER_W        = 32;

	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_OLDEST = 2'd1;

	typedef enum logic [1:0] {
		ST_STORED = 2'd0,
		ST_SERVED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_DRAIN,
		S_REMOVE,
		S_SKIP
	} state_t;

	typedef struct packed {
		logic    load;
		logic    write_arrive;
		logic    scan_start;
		logic    scan_step;
		logic    remove;
		logic    skip_step;
		logic    finish;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic is_arrive;
		logic full;
		logic empty;
		logic scan_last;
		logic occ_one;
		logic head_valid;
	} stat_t;

endpackage

// File: hdl/orsq_ctrl.sv
// Controller state machine of the service queue.
// Depends on orsq_pkg.
`timescale 1ns / 1ps
module orsq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  orsq_pkg::stat_t stat,
	output orsq_pkg::cmd_t  cmd,
	output logic            busy
);

	orsq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orsq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			orsq_pkg::S_IDLE: begin
				if (start) begin
					state_d = orsq_pkg::S_EXEC;
				end
			end
			orsq_pkg::S_EXEC: begin
				if (stat.is_arrive || stat.empty) begin
					state_d = orsq_pkg::S_IDLE;
				end else begin
					state_d = orsq_pkg::S_SCAN;
				end
			end
			orsq_pkg::S_SCAN: begin
				if (stat.scan_last) begin
					state_d = orsq_pkg::S_DRAIN;
				end
			end
			orsq_pkg::S_DRAIN: begin
				state_d = orsq_pkg::S_REMOVE;
			end
			orsq_pkg::S_REMOVE: begin
				if (stat.occ_one) begin
					state_d = orsq_pkg::S_IDLE;
				end else begin
					state_d = orsq_pkg::S_SKIP;
				end
			end
			orsq_pkg::S_SKIP: begin
				if (stat.head_valid) begin
					state_d = orsq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = orsq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			orsq_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			orsq_pkg::S_EXEC: begin
				if (stat.is_arrive) begin
					cmd.finish = 1'b1;
					if (stat.full) begin
						cmd.code = orsq_pkg::ST_FULL;
					end else begin
						cmd.write_arrive = 1'b1;
						cmd.code         = orsq_pkg::ST_STORED;
					end
				end else if (stat.empty) begin
					cmd.finish = 1'b1;
					cmd.code   = orsq_pkg::ST_EMPTY;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			orsq_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			orsq_pkg::S_DRAIN: begin
			end
			orsq_pkg::S_REMOVE: begin
				cmd.remove = 1'b1;
				if (stat.occ_one) begin
					cmd.finish = 1'b1;
					cmd.code   = orsq_pkg::ST_SERVED;
				end
			end
			orsq_pkg::S_SKIP: begin
				if (stat.head_valid) begin
					cmd.finish = 1'b1;
					cmd.code   = orsq_pkg::ST_SERVED;
				end else begin
					cmd.skip_step = 1'b1;
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// File: hdl/orsq_datapath.sv
// Datapath of the service queue: entry memory, valid bits, ring pointers,
// the largest-value scan and the result register. Depends on orsq_pkg.
`timescale 1ns / 1ps
`include "oldest_or_richest_service_queue_defines.svh"
module orsq_datapath #(
	parameter int CAPACITY    = orsq_pkg::CAPACITY_DEF,
	parameter int AMOUNT_BITS = orsq_pkg::AMOUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    op,
	input  logic [31:0]                   amount,
	input  orsq_pkg::cmd_t                cmd,
	output orsq_pkg::stat_t               stat,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [orsq_pkg::NUMBER_W-1:0] served_number
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int OCC_W  = $clog2(CAPACITY + 1);
	localparam int NUM_W  = orsq_pkg::NUMBER_W;
	localparam int WORD_W = AMOUNT_BITS + NUM_W;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(CAPACITY - 1)) ? '0 : s + 1'b1;
	endfunction

	logic [1:0]             op_q;
	logic [AMOUNT_BITS-1:0] amt_q;
	logic [AMOUNT_BITS+31:0] amt_wide;
	logic [WORD_W-1:0]      mem_q [CAPACITY];
	logic [WORD_W-1:0]      rd_data_s1;
	logic [CAPACITY-1:0]    valid_q;
	logic [SLOT_W-1:0]      head_q, tail_q, scan_slot_q, cnt_q, slot_s1, best_slot_q;
	logic [OCC_W-1:0]       occ_q;
	logic [NUM_W-1:0]       next_num_q, best_num_q, number_q;
	logic [AMOUNT_BITS-1:0] best_amt_q, rd_amt;
	logic                   scan_all_q, cmp_s1, vld_s1, found_q, done_q;
	logic [1:0]             status_q;

	assign amt_wide = {{AMOUNT_BITS{1'b0}}, amount};
	assign rd_amt   = rd_data_s1[WORD_W-1:NUM_W];

	assign stat.is_arrive  = (op_q == orsq_pkg::OP_ARRIVE);
	assign stat.full       = valid_q[tail_q];
	assign stat.empty      = (occ_q == '0);
	assign stat.scan_last  = !scan_all_q || (cnt_q == SLOT_W'(CAPACITY - 1));
	assign stat.occ_one    = (occ_q == OCC_W'(1));
	assign stat.head_valid = valid_q[head_q];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			amt_q <= amt_wide[AMOUNT_BITS-1:0];
		end
		if (cmd.write_arrive) begin
			mem_q[tail_q] <= {amt_q, next_num_q};
		end
		rd_data_s1 <= mem_q[scan_slot_q];
		slot_s1    <= scan_slot_q;
		vld_s1     <= valid_q[scan_slot_q];
		if (cmd.finish) begin
			status_q <= cmd.code;
			case (cmd.code)
				orsq_pkg::ST_STORED: number_q <= next_num_q;
				orsq_pkg::ST_SERVED: number_q <= best_num_q;
				default:             number_q <= '0;
			endcase
		end
		if (cmp_s1 && vld_s1 && (!found_q || rd_amt > best_amt_q)) begin
			best_amt_q  <= rd_amt;
			best_num_q  <= rd_data_s1[NUM_W-1:0];
			best_slot_q <= slot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			next_num_q  <= NUM_W'(1);
			scan_slot_q <= '0;
			cnt_q       <= '0;
			scan_all_q  <= 1'b0;
			cmp_s1      <= 1'b0;
			found_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			cmp_s1 <= cmd.scan_step;
			if (cmp_s1 && vld_s1) begin
				found_q <= 1'b1;
			end
			if (cmd.write_arrive) begin
				valid_q[tail_q] <= 1'b1;
				if (next_num_q != '1) begin
					next_num_q <= next_num_q + 1'b1;
				end
				if (occ_q == '0) begin
					head_q <= tail_q;
				end
				occ_q  <= occ_q + 1'b1;
				tail_q <= slot_next(tail_q);
			end
			if (cmd.scan_start) begin
				scan_slot_q <= head_q;
				cnt_q       <= '0;
				scan_all_q  <= (op_q != orsq_pkg::OP_OLDEST);
				found_q     <= 1'b0;
			end
			if (cmd.scan_step) begin
				scan_slot_q <= slot_next(scan_slot_q);
				cnt_q       <= cnt_q + 1'b1;
			end
			if (cmd.remove) begin
				valid_q[best_slot_q] <= 1'b0;
				occ_q                <= occ_q - 1'b1;
				if (occ_q == OCC_W'(1)) begin
					head_q <= tail_q;
				end
			end
			if (cmd.skip_step) begin
				head_q <= slot_next(head_q);
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign served_number = number_q;

	`ORSQ_ASSERT(a_occ_bound, occ_q <= OCC_W'(CAPACITY), "occupancy above capacity")
	`ORSQ_ASSERT(a_occ_count, !cmd.load || ($countones(valid_q) == int'(occ_q)), "occupancy does not match valid bits")
	`ORSQ_ASSERT(a_head_valid, !cmd.load || occ_q == '0 || valid_q[head_q], "head not on a waiting entry while idle")
	`ORSQ_ASSERT(a_remove_valid, !cmd.remove || valid_q[best_slot_q], "removal of an empty slot")

endmodule

// File: hdl/oldest_or_richest_service_queue.sv
// Top level of the oldest-or-richest service queue.
// Depends on orsq_pkg, orsq_ctrl and orsq_datapath.
//
//   channel   handshake          words carried
//   command   start / busy       op, amount
//   result    done (strobe)      status, served_number
//
// An arrival or a request on an empty table is answered straight from the execute state.
// Serve oldest reads the head slot only and serve largest reads every slot:
// the single entry memory read port walks the ring one slot a cycle, then
// the head pointer skips served holes one slot a cycle.
// Reset clears the table at once; no clearing pass follows. done is high for
// one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
`include "oldest_or_richest_service_queue_defines.svh"
module oldest_or_richest_service_queue #(
	parameter int CAPACITY    = orsq_pkg::CAPACITY_DEF,
	parameter int AMOUNT_BITS = orsq_pkg::AMOUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    op,
	input  logic [31:0]                   amount,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [orsq_pkg::NUMBER_W-1:0] served_number
);

	orsq_pkg::cmd_t  cmd;
	orsq_pkg::stat_t stat;

	orsq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	orsq_datapath #(
		.CAPACITY    (CAPACITY),
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.amount        (amount),
		.cmd           (cmd),
		.stat          (stat),
		.done          (done),
		.status        (status),
		.served_number (served_number)
	);

	`ORSQ_ASSERT(a_done_idle, !done || !busy, "result strobe while busy")
	`ORSQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`ORSQ_ASSERT(a_served_nonzero, !(done && status == orsq_pkg::ST_SERVED) || served_number != '0, "served entry with number zero")
	`ORSQ_ASSERT(a_reject_zero, !(done && (status == orsq_pkg::ST_EMPTY || status == orsq_pkg::ST_FULL)) || served_number == '0, "rejected word with nonzero number")

endmodule

// File: bench/oldest_or_richest_service_queue_test.sv
// Self-checking testbench for the oldest-or-richest service queue.
// Depends on orsq_pkg and oldest_or_richest_service_queue; it predicts each result word
// from its own copy of the waiting table and checks every done strobe against it.
`timescale 1ns / 1ps
module oldest_or_richest_service_queue_test;
	import orsq_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam logic [1:0] OP_LARGEST = 2'd2;
	localparam logic [1:0] OP_LARGEST_ALIAS = 2'd3;
	localparam int SETTLE_CYCLES = 2 * CAP + 8;
	localparam int STALL_LIMIT = 8 * SETTLE_CYCLES;

	typedef struct packed {
		status_t     code;
		logic [31:0] number;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [31:0] amount;
	logic        done;
	logic [1:0]  status;
	logic [NUMBER_W-1:0] served_number;

	logic [31:0] ring_amount [CAP];
	logic [31:0] ring_number [CAP];
	logic        ring_taken [CAP];
	int unsigned ring_head;
	int unsigned ring_tail;
	int unsigned ring_count;
	logic [31:0] number_next;

	reply_t      replies_due [$];
	logic        taken;
	int unsigned gap_pct;
	int unsigned stalled_cycles;
	int unsigned mismatches;
	int unsigned requests_sent;
	int unsigned stored_count;
	int unsigned served_count;
	int unsigned empty_count;
	int unsigned full_count;
	int unsigned peak_count;

	oldest_or_richest_service_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.amount       (amount),
		.done         (done),
		.status       (status),
		.served_number(served_number)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned step_slot(input int unsigned slot);
		return (slot + 1 >= CAP) ? 0 : slot + 1;
	endfunction

	task automatic take_out(input int unsigned slot, output logic [31:0] num);
		int k;
		num = ring_number[slot];
		ring_taken[slot] = 1'b0;
		if (ring_count > 0)
			ring_count--;
		if (ring_count == 0) begin
			ring_head = ring_tail;
		end else begin
			for (k = 0; k < CAP && !ring_taken[ring_head]; k++)
				ring_head = step_slot(ring_head);
		end
	endtask

	task automatic resolve_request(input logic [1:0] req_op, input logic [31:0] req_amount,
			output reply_t rep);
		int unsigned slot;
		int unsigned best;
		logic [31:0] best_amount;
		int k;
		rep.number = '0;
		if (req_op == OP_ARRIVE) begin
			if (ring_taken[ring_tail]) begin
				rep.code = ST_FULL;
			end else begin
				ring_amount[ring_tail] = req_amount;
				ring_number[ring_tail] = number_next;
				ring_taken[ring_tail] = 1'b1;
				rep.number = number_next;
				if (number_next != 32'hFFFF_FFFF)
					number_next++;
				if (ring_count == 0)
					ring_head = ring_tail;
				ring_count++;
				ring_tail = step_slot(ring_tail);
				rep.code = ST_STORED;
			end
		end else if (ring_count == 0) begin
			rep.code = ST_EMPTY;
		end else if (req_op == OP_OLDEST) begin
			take_out(ring_head, rep.number);
			rep.code = ST_SERVED;
		end else begin
			slot = ring_head;
			best = ring_head;
			best_amount = ring_amount[ring_head];
			for (k = 0; k < CAP; k++) begin
				if (ring_taken[slot] && ring_amount[slot] > best_amount) begin
					best = slot;
					best_amount = ring_amount[slot];
				end
				slot = step_slot(slot);
			end
			take_out(best, rep.number);
			rep.code = ST_SERVED;
		end
	endtask

	always @(posedge clk) begin
		reply_t want;
		reply_t fresh;
		if (arst_n) begin
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("unexpected word: status %0d, served_number %0d", status,
						served_number);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, status);
						mismatches++;
					end
					if (served_number !== want.number) begin
						$error("served_number: expected %0d, got %0d", want.number,
							served_number);
						mismatches++;
					end
				end
			end
			if (start && !busy) begin
				resolve_request(op, amount, fresh);
				replies_due.push_back(fresh);
				requests_sent++;
				case (fresh.code)
					ST_STORED: stored_count++;
					ST_SERVED: served_count++;
					ST_EMPTY:  empty_count++;
					default:   full_count++;
				endcase
				if (ring_count > peak_count)
					peak_count = ring_count;
			end
			taken <= start && !busy;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done || (start && !busy)) begin
				stalled_cycles <= 0;
			end else if (stalled_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end else begin
				stalled_cycles <= stalled_cycles + 1;
			end
		end
	end

	function automatic logic [31:0] draw_amount();
		case ($urandom_range(3))
			0: return $urandom_range(3);
			1: begin
				case ($urandom_range(3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] draw_serve();
		case ($urandom_range(2))
			0: return OP_OLDEST;
			1: return OP_LARGEST;
			default: return OP_LARGEST_ALIAS;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic issue_request(input logic [1:0] req_op, input logic [31:0] req_amount);
		while ($urandom_range(99) < gap_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		if (gap_pct > 0 && $urandom_range(49) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, SETTLE_CYCLES)) @(negedge clk);
		end
		op = req_op;
		amount = req_amount;
		start = 1'b1;
		do
			@(negedge clk);
		while (!taken);
	endtask

	task automatic wait_for_replies();
		start = 1'b0;
		while (replies_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_table();
		issue_request(OP_OLDEST, 32'hFFFF_FFFF);
		issue_request(OP_LARGEST, 32'h0000_0000);
		issue_request(OP_LARGEST_ALIAS, 32'h1234_5678);
	endtask

	task automatic test_ordering_and_ties();
		issue_request(OP_ARRIVE, 32'h0000_0000);
		issue_request(OP_ARRIVE, 32'hFFFF_FFFF);
		issue_request(OP_ARRIVE, 32'h0000_0007);
		issue_request(OP_ARRIVE, 32'h0000_0007);
		issue_request(OP_ARRIVE, 32'h0000_0001);
		issue_request(OP_LARGEST, 32'h0000_0000);
		issue_request(OP_LARGEST_ALIAS, 32'hFFFF_FFFF);
		issue_request(OP_OLDEST, 32'hFFFF_FFFF);
		issue_request(OP_OLDEST, 32'h0000_0000);
		issue_request(OP_LARGEST, 32'hAAAA_AAAA);
		issue_request(OP_OLDEST, 32'h5555_5555);
		issue_request(OP_ARRIVE, 32'h8000_0000);
		issue_request(OP_ARRIVE, 32'h7FFF_FFFF);
		issue_request(OP_LARGEST, 32'h0000_0000);
		issue_request(OP_LARGEST, 32'h0000_0000);
	endtask

	// The ring counts as full when the tail slot is occupied, even with holes behind it.
	task automatic test_full_ring_with_holes();
		int i;
		for (i = 0; i < CAP; i++)
			issue_request(OP_ARRIVE, draw_amount());
		issue_request(OP_ARRIVE, draw_amount());
		issue_request(OP_LARGEST, draw_amount());
		issue_request(OP_LARGEST_ALIAS, draw_amount());
		issue_request(OP_ARRIVE, draw_amount());
		issue_request(OP_OLDEST, draw_amount());
		issue_request(OP_ARRIVE, draw_amount());
		issue_request(OP_ARRIVE, draw_amount());
		while (ring_count > 0)
			issue_request(draw_serve(), draw_amount());
		issue_request(OP_OLDEST, draw_amount());
		wait_for_replies();
	endtask

	task automatic run_traffic(input int unsigned pct, input int unsigned items);
		int unsigned sent;
		int unsigned run_len;
		int unsigned arrive_pct;
		int unsigned i;
		gap_pct = pct;
		sent = 0;
		while (sent < items) begin
			case ($urandom_range(2))
				0: arrive_pct = 85;
				1: arrive_pct = 20;
				default: arrive_pct = 50;
			endcase
			run_len = $urandom_range(8, 80);
			for (i = 0; i < run_len && sent < items; i++) begin
				if ($urandom_range(99) < arrive_pct)
					issue_request(OP_ARRIVE, draw_amount());
				else
					issue_request(draw_serve(), draw_amount());
				sent++;
			end
		end
		wait_for_replies();
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_ARRIVE;
		amount = '0;
		taken = 1'b0;
		stalled_cycles = 0;
		mismatches = 0;
		requests_sent = 0;
		stored_count = 0;
		served_count = 0;
		empty_count = 0;
		full_count = 0;
		peak_count = 0;
		gap_pct = 17;
		for (k = 0; k < CAP; k++) begin
			ring_amount[k] = '0;
			ring_number[k] = '0;
			ring_taken[k] = 1'b0;
		end
		ring_head = 0;
		ring_tail = 0;
		ring_count = 0;
		number_next = 32'd1;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		test_ordering_and_ties();
		test_full_ring_with_holes();
		run_traffic(17, 235);
		run_traffic(87, 235);
		run_traffic(0, 235);

		wait_for_replies();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Checked %0d requests: %0d arrivals stored, %0d entries served,",
			requests_sent, stored_count, served_count);
		$display("%0d serves on an empty table, %0d arrivals refused; peak fill %0d of %0d.",
			empty_count, full_count, peak_count, CAP);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/orsq_pkg.sv
hdl/orsq_ctrl.sv
hdl/orsq_datapath.sv
hdl/oldest_or_richest_service_queue.sv
bench/oldest_or_richest_service_queue_test.sv
